FILE: rtl/ppic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppic_pkg
// shared types and codes of the parallel i/o port controller
// ----------------------------------------------------------------------------
package ppic_pkg;

  typedef enum logic [1:0] {
    CMD_CPU_WR   = 2'd0,
    CMD_CPU_RD   = 2'd1,
    CMD_PERIPH_WR = 2'd2,
    CMD_PERIPH_RD = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SEL_PORT_A = 2'd0,
    SEL_PORT_B = 2'd1,
    SEL_PORT_C = 2'd2,
    SEL_CTRL   = 2'd3
  } sel_e;

  localparam logic [7:0] CW_RESET  = 8'h9B;
  localparam logic [7:0] PINS_PULL = 8'hFF;

  // architectural state
  typedef struct packed {
    logic [7:0] cw;
    logic [7:0] lat_a;
    logic [7:0] lat_b;
    logic [7:0] lat_c;
    logic [7:0] pin_a;
    logic [7:0] pin_b;
    logic [7:0] pin_c;
    logic [7:0] stb_a;
    logic [7:0] stb_b;
    logic [2:0] ie;
  } state_t;

  // one input transaction
  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] sel;
    logic [7:0] data;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_c_latch;
    logic       c_changed;
    logic       c_hi_changed;
    logic       c_lo_changed;
    logic       a_written;
    logic       b_written;
    logic       mode_set;
    logic [3:0] rd_req;
    logic       bad_port;
  } result_t;

endpackage

FILE: rtl/ppic_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppic_core
// next-state and result logic for one access
// ----------------------------------------------------------------------------
module ppic_core (
  input  ppic_pkg::state_t  st_i,
  input  ppic_pkg::item_t   item_i,
  output ppic_pkg::state_t  st_o,
  output ppic_pkg::result_t res_o
);
  import ppic_pkg::*;

  function automatic logic [7:0] cpu_read_c(input state_t s);
    logic [7:0] cw, lc, pc, r;
    cw = s.cw; lc = s.lat_c; pc = s.pin_c; r = 8'h00;
    if (cw[2] == 1'b0 && cw[0] == 1'b0) r = r | (lc & 8'h0F);
    else if (cw[2] == 1'b0 && cw[0] == 1'b1) r = r | (pc & 8'h0F);
    if ((cw & 8'h68) == 8'h00) r = r | (lc & 8'hF0);
    else if ((cw & 8'h68) == 8'h08) r = r | (pc & 8'hF0);
    if ((cw & 8'h60) == 8'h20) begin
      r = (r & 8'h07) | (lc & 8'h08);
      if (cw[4]) begin
        if (s.ie[0]) r = r | 8'h10;
        r = r | (lc & 8'h20);
        r = r | ((cw[3] ? pc : lc) & 8'hC0);
      end else begin
        if (s.ie[1]) r = r | 8'h40;
        r = r | (lc & 8'h80);
        r = r | ((cw[3] ? pc : lc) & 8'h30);
      end
    end else if ((cw & 8'h60) == 8'h40) begin
      r = (r & 8'h07) | (lc & 8'hA8);
      if (s.ie[0]) r = r | 8'h10;
      if (s.ie[1]) r = r | 8'h40;
    end
    if (cw[2]) begin
      r = (r & 8'hF8) | (lc & 8'h03);
      if (s.ie[2]) r = r | 8'h04;
    end
    return r;
  endfunction

  function automatic logic [7:0] periph_read_c(input state_t s);
    logic [7:0] cw, lc, pc, r;
    cw = s.cw; lc = s.lat_c; pc = s.pin_c; r = 8'h00;
    if ((cw & 8'h05) == 8'h00) r = r | (lc & 8'h07);
    else if ((cw & 8'h05) == 8'h01) r = r | (pc & 8'h07);
    else r = r | (lc & 8'h03) | (pc & 8'h04);
    if ((cw & 8'h68) == 8'h00) r = r | (lc & 8'hF0);
    else if ((cw & 8'h68) == 8'h08) r = r | (pc & 8'hF0);
    else if ((cw & 8'h70) == 8'h20) begin
      r = r | (lc & 8'h88) | (pc & 8'h40);
      r = r | ((cw[3] ? pc : lc) & 8'h30);
    end else if ((cw & 8'h70) == 8'h30) begin
      r = r | (lc & 8'h28) | (pc & 8'h10);
      r = r | ((cw[3] ? pc : lc) & 8'hC0);
    end else if ((cw & 8'h60) == 8'h40) begin
      r = r | (lc & 8'hA8) | (pc & 8'h50);
    end
    if ((cw & 8'h60) == 8'h00) r = r | ((cw[0] ? pc : lc) & 8'h08);
    return r;
  endfunction

  always_comb begin
    state_t     n;
    logic [7:0] cw, d, rd, diff, mh, ml, w, m;
    logic [3:0] req, v;
    logic [2:0] bitn;
    logic       aw, bw, ms, bad, a2, inte, ok;
    logic       b0clo, b0cli, a0cho, a0chi;
    n = st_i; cw = st_i.cw; d = item_i.data;
    rd = 8'h00; req = 4'h0; aw = 1'b0; bw = 1'b0; ms = 1'b0; bad = 1'b0;
    w = 8'h00; m = 8'h00; v = d[3:0]; bitn = v[3:1];
    a2 = (cw[6:5] == 2'b10); inte = 1'b0; ok = 1'b0;
    b0clo = (cw[2] == 1'b0) && (cw[0] == 1'b0);
    b0cli = (cw[2] == 1'b0) && (cw[0] == 1'b1);
    a0cho = (cw & 8'h68) == 8'h00;
    a0chi = (cw & 8'h68) == 8'h08;
    case (item_i.cmd)
      CMD_CPU_WR: begin
        case (item_i.sel)
          SEL_PORT_A: begin
            n.lat_a = d;
            if (cw[6:5] == 2'b00) aw = 1'b1;
            else n.lat_c = n.lat_c & 8'h77;
          end
          SEL_PORT_B: begin
            n.lat_b = d;
            if (!cw[2]) bw = 1'b1;
            else n.lat_c = n.lat_c & 8'hFC;
          end
          SEL_PORT_C: begin
            if (b0clo && a0cho) n.lat_c = d;
            else if (b0clo && a0chi) n.lat_c = (n.lat_c & 8'hF0) | (d & 8'h0F);
            else if (b0clo) n.lat_c = (n.lat_c & 8'hF8) | (d & 8'h07);
            else if (a0cho) n.lat_c = (n.lat_c & 8'h0F) | (d & 8'hF0);
          end
          default: begin
            if (d[7]) begin
              // mode set, mode 3 of group a folds into mode 2
              w = d;
              if (w[6:5] == 2'b11) w[5] = 1'b0;
              n.cw    = w;
              n.pin_a = PINS_PULL; n.lat_a = 8'h00;
              n.pin_b = PINS_PULL; n.lat_b = 8'h00;
              if (w[2]) n.stb_b = 8'h00;
              n.pin_c = (w[2] ? 8'h00 : 8'h07) | ((w[6:5] != 2'b00) ? 8'h00 : 8'hF8);
              n.lat_c = (w[2] ? 8'h02 : 8'h00) | ((w[6:5] != 2'b00) ? 8'h80 : 8'h00);
              n.ie    = 3'b000;
              ms = 1'b1;
            end else begin
              // port c bit set/reset
              if (((cw & 8'h70) == 8'h30 || a2) && bitn == 3'd4) begin
                n.ie[0] = v[0]; inte = 1'b1;
              end else if (((cw & 8'h70) == 8'h20 || a2) && bitn == 3'd6) begin
                n.ie[1] = v[0]; inte = 1'b1;
              end
              if (inte) begin
                n.lat_c[3] = 1'b0;
                if ((n.ie[0] && n.pin_c[4] && n.lat_c[5]) ||
                    (n.ie[1] && n.pin_c[6] && n.lat_c[7])) n.lat_c[3] = 1'b1;
              end
              if (cw[2] && bitn == 3'd2) begin
                inte = 1'b1;
                n.ie[2] = v[0];
                n.lat_c[0] = n.ie[2] && n.pin_c[2] && n.lat_c[1];
              end
              if (!inte) begin
                ok = (b0clo && a0cho) || (b0clo && a0chi && bitn <= 3'd3) ||
                     (b0cli && a0cho && bitn >= 3'd4) || (b0clo && bitn <= 3'd2) ||
                     (a0cho && bitn >= 3'd4) ||
                     ((cw & 8'h65) == 8'h04 && bitn == 3'd3) ||
                     ((cw & 8'h78) == 8'h30 && bitn >= 3'd6) ||
                     ((cw & 8'h78) == 8'h20 && (bitn == 3'd4 || bitn == 3'd5));
                if (ok) begin
                  m = 8'h01 << bitn;
                  if (v[0]) n.lat_c = n.lat_c | m;
                  else n.lat_c = n.lat_c & ~m;
                end
              end
            end
          end
        endcase
      end
      CMD_CPU_RD: begin
        case (item_i.sel)
          SEL_PORT_A: begin
            if ((cw & 8'h70) == 8'h10) begin
              rd = st_i.pin_a; req[0] = 1'b1;
            end else if ((cw & 8'h70) == 8'h00) rd = st_i.lat_a & st_i.pin_a;
            else if ((cw & 8'h70) == 8'h20) rd = st_i.lat_a;
            else begin
              rd = st_i.stb_a; n.lat_c = n.lat_c & 8'hD7;
            end
          end
          SEL_PORT_B: begin
            if (cw[2:1] == 2'b01) begin
              rd = st_i.pin_b; req[1] = 1'b1;
            end else if (cw[2:1] == 2'b11) begin
              rd = st_i.stb_b; n.lat_c = n.lat_c & 8'hFC;
            end else rd = st_i.lat_b;
          end
          SEL_PORT_C: begin
            if (a0chi) req[2] = 1'b1;
            if (b0cli) req[3] = 1'b1;
            rd = cpu_read_c(st_i);
          end
          default: rd = cw;
        endcase
      end
      CMD_PERIPH_WR: begin
        case (item_i.sel)
          SEL_PORT_A: n.pin_a = d;
          SEL_PORT_B: n.pin_b = d;
          SEL_PORT_C: begin
            // strobe / acknowledge edges on the pins
            if (cw[2]) begin
              if (st_i.pin_c[2] && !d[2]) begin
                if (cw[1]) n.stb_b = st_i.pin_b;
                n.lat_c[1] = 1'b1;
                n.lat_c[0] = 1'b0;
              end else if (!st_i.pin_c[2] && d[2]) begin
                n.lat_c[0] = n.ie[2] && n.lat_c[1];
              end
            end
            if (cw[6:5] != 2'b00) begin
              if (a2 || (cw & 8'h70) == 8'h30) begin
                if (st_i.pin_c[4] && !d[4]) begin
                  n.stb_a = st_i.pin_a;
                  n.lat_c[5] = 1'b1; n.lat_c[3] = 1'b0;
                end else if (!st_i.pin_c[4] && d[4]) begin
                  n.lat_c[3] = n.ie[0] && n.lat_c[5];
                end
              end
              if (a2 || (cw & 8'h70) == 8'h20) begin
                if (st_i.pin_c[6] && !d[6]) begin
                  n.lat_c[7] = 1'b1; n.lat_c[3] = 1'b0;
                end else if (!st_i.pin_c[6] && d[6]) begin
                  n.lat_c[3] = n.ie[1] && n.lat_c[7];
                end
              end
            end
            n.pin_c = d;
          end
          default: bad = 1'b1;
        endcase
      end
      default: begin
        case (item_i.sel)
          SEL_PORT_A: begin
            if (a2) begin
              if (!st_i.lat_c[7]) rd = st_i.lat_a;
              else if (!st_i.lat_c[5]) rd = st_i.pin_a;
              else rd = 8'hFF;
            end else rd = cw[4] ? st_i.pin_a : st_i.lat_a;
          end
          SEL_PORT_B: rd = cw[1] ? st_i.pin_b : st_i.lat_b;
          SEL_PORT_C: rd = periph_read_c(st_i);
          default: begin
            rd = 8'hFF; bad = 1'b1;
          end
        endcase
      end
    endcase

    diff = ms ? 8'hFF : (st_i.lat_c ^ n.lat_c);
    if ((n.cw & 8'h64) != 8'h00) begin
      mh = 8'hF8; ml = 8'h07;
    end else begin
      mh = 8'hF0; ml = 8'h0F;
    end

    st_o                = n;
    res_o.read_data     = rd;
    res_o.port_c_latch  = n.lat_c;
    res_o.c_changed     = |diff;
    res_o.c_hi_changed  = |(diff & mh);
    res_o.c_lo_changed  = |(diff & ml);
    res_o.a_written     = aw;
    res_o.b_written     = bw;
    res_o.mode_set      = ms;
    res_o.rd_req        = req;
    res_o.bad_port      = bad;
  end

endmodule

FILE: rtl/parallel_io_port_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_io_port_controller
// three-port programmable parallel interface with handshake modes 0, 1 and 2
// ----------------------------------------------------------------------------
// datapath: an input transaction is held in the input register, then makes one
//   pass through the single-pass access logic into the result register
// throughput: one transaction per cycle unless the full result register stalls
// reset: control word 0x9b (all ports mode 0 inputs), pins pulled high,
//   latches and interrupt enables cleared, both pipeline stages empty
module parallel_io_port_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [1:0] port_sel_i,
  input  logic [7:0] data_in_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [7:0] port_c_latch_o,
  output logic       port_c_changed_o,
  output logic       port_c_hi_changed_o,
  output logic       port_c_lo_changed_o,
  output logic       port_a_written_o,
  output logic       port_b_written_o,
  output logic       mode_set_o,
  output logic [3:0] input_read_request_o,
  output logic       bad_port_o
);
  import ppic_pkg::*;

  state_t  st_q, st_d;
  item_t   item_q;
  logic    item_vld_q;
  result_t res_q, res_d;
  logic    res_vld_q;
  logic    advance;
  logic    in_accept;

  // the access stage moves whenever the result register is free or drained
  assign advance    = !res_vld_q || !out_stall_i;
  assign in_stall_o = item_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  ppic_core u_core (
    .st_i   (st_q),
    .item_i (item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_accept) begin
      item_vld_q <= 1'b1;
    end else if (advance) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{cmd: cmd_i, sel: port_sel_i, data: data_in_i};
    end
  end

  // port state commits together with the result of the access
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{cw: CW_RESET, lat_a: 8'h00, lat_b: 8'h00, lat_c: 8'h00,
                pin_a: PINS_PULL, pin_b: PINS_PULL, pin_c: PINS_PULL,
                stb_a: 8'h00, stb_b: 8'h00, ie: 3'b000};
    end else if (item_vld_q && advance) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_vld_q && advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = res_vld_q;
  assign read_data_o          = res_q.read_data;
  assign port_c_latch_o       = res_q.port_c_latch;
  assign port_c_changed_o     = res_q.c_changed;
  assign port_c_hi_changed_o  = res_q.c_hi_changed;
  assign port_c_lo_changed_o  = res_q.c_lo_changed;
  assign port_a_written_o     = res_q.a_written;
  assign port_b_written_o     = res_q.b_written;
  assign mode_set_o           = res_q.mode_set;
  assign input_read_request_o = res_q.rd_req;
  assign bad_port_o           = res_q.bad_port;

endmodule
